// ===== sv/lzsd_pkg.sv =====
// lzsd_pkg: widths, status and parse codes, the flag walk helper and the
// truncation status helper for the lzss stream decompressor; no dependencies
package lzsd_pkg;

  localparam int LZSD_WINDOW = 4096;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 24;
  localparam int OFF_W       = 12;
  localparam int LEFT_W      = 4;
  localparam int RUN_W       = 5;

  localparam logic [CNT_W-1:0]  MAX_RESET     = 24'hFFFFFF;
  localparam logic [LEFT_W-1:0] FLAGS_PER_TAG = 4'd8;
  localparam logic [RUN_W-1:0]  MIN_MATCH     = 5'd2;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_END      = 3'd1,
    ST_NO_TAG   = 3'd2,
    ST_NO_LIT   = 3'd3,
    ST_NO_REF   = 3'd4,
    ST_LIT_OVF  = 3'd5,
    ST_COPY_OVF = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    PH_FLAG  = 4'b0001,
    PH_LIT   = 4'b0010,
    PH_REFLO = 4'b0100,
    PH_REFHI = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bits;
    logic [LEFT_W-1:0] left;
    phase_t            phase;
  } code_t;

  // step to the next code of the current flag word
  function automatic code_t next_code(input logic [BYTE_W-1:0] bits,
                                      input logic [LEFT_W-1:0] left);
    code_t c;
    c.bits = bits >> 1;
    c.left = (left != '0) ? left - LEFT_W'(1) : left;
    if (c.left == '0) begin
      c.phase = PH_FLAG;
    end else if (c.bits[0]) begin
      c.phase = PH_REFLO;
    end else begin
      c.phase = PH_LIT;
    end
    return c;
  endfunction

  // status for a stream cut off while waiting in the given phase
  function automatic status_t trunc_status(input phase_t ph);
    status_t s;
    unique case (ph)
      PH_FLAG: s = ST_NO_TAG;
      PH_LIT:  s = ST_NO_LIT;
      default: s = ST_NO_REF;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/lzsd_if.sv =====
// lzsd_in_if and lzsd_out_if: valid/ready channels for compressed input
// words and decompressed result words; depend on lzsd_pkg
interface lzsd_in_if import lzsd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, in_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, first_byte, last_byte, output ready);
endinterface

interface lzsd_out_if import lzsd_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  status_t           status;
  logic              last_of_run;

  modport source (output valid, out_byte, status, last_of_run, input ready);
  modport sink   (input valid, out_byte, status, last_of_run, output ready);
endinterface

// ===== sv/lzsd_ram.sv =====
// lzsd_ram: generic simple dual-port ram, one write port and one read
// port with registered read data; no dependencies
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lzss_stream_decompressor_core.sv =====
// lzss stream decompressor: literal results and status results of words with no data are
// valid in the cycle after the word is taken; a copy's first byte passes the ring's read
// register, then the output register; a reference high word starts a copy of 2..17 bytes
// with input not ready until all are sent; truncation after data follows from S_TAIL;
// a stalled output stalls all; after reset a clearing pass writes zero to all WINDOW_SIZE
// (4096) ring entries, one per cycle, input not ready; config register is taken throughout
module lzss_stream_decompressor_core import lzsd_pkg::*; #(
  parameter int WINDOW_SIZE = LZSD_WINDOW
) (
  input  logic             clk,
  input  logic             rst_n,
  lzsd_in_if.sink          in_chan,
  lzsd_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(WINDOW_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_COPY  = 4'b0100,
    S_TAIL  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] flag_bits_r, flag_bits_nxt;
  logic [LEFT_W-1:0] flags_left_r, flags_left_nxt;
  logic [BYTE_W-1:0] ref_low_r, ref_low_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  max_r, max_nxt;
  logic              halted_r, halted_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [RUN_W-1:0]  copy_left_r, copy_left_nxt;
  logic              fwd_r, fwd_nxt;
  logic [BYTE_W-1:0] fwd_data_r, fwd_data_nxt;
  logic              tail_pend_r, tail_pend_nxt;
  status_t           tail_status_r, tail_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic              out_free, in_ready, in_acc, out_load;

  // working values of one accepted word
  phase_t            ph;
  logic [BYTE_W-1:0] fb;
  logic [LEFT_W-1:0] fl;
  logic [CNT_W-1:0]  cnt_e;
  logic [AW-1:0]     wp_e;
  logic              hlt;
  logic              ok, lit_out, copy_go;
  logic [OFF_W-1:0]  offset;
  logic [RUN_W-1:0]  run_len;
  logic [BYTE_W-1:0] copy_data;
  code_t             nc;

  lzsd_ram #(.WIDTH(BYTE_W), .DEPTH(WINDOW_SIZE)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_chan.valid && in_ready;

  assign offset    = {in_chan.in_byte, ref_low_r[7:4]};
  assign run_len   = RUN_W'(ref_low_r[3:0]) + MIN_MATCH;
  // a read issued at the address written in the same cycle gets the new byte
  assign copy_data = fwd_r ? fwd_data_r : ram_rdata;

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    flag_bits_nxt   = flag_bits_r;
    flags_left_nxt  = flags_left_r;
    ref_low_nxt     = ref_low_r;
    cnt_nxt         = cnt_r;
    max_nxt         = cfg_we ? cfg_wdata : max_r;
    halted_nxt      = halted_r;
    wp_nxt          = wp_r;
    clr_addr_nxt    = clr_addr_r;
    rd_addr_nxt     = rd_addr_r;
    copy_left_nxt   = copy_left_r;
    fwd_nxt         = fwd_r;
    fwd_data_nxt    = fwd_data_r;
    tail_pend_nxt   = tail_pend_r;
    tail_status_nxt = tail_status_r;
    out_load        = 1'b0;
    out_byte_nxt    = out_byte_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    ram_we          = 1'b0;
    ram_waddr       = wp_r;
    ram_wdata       = copy_data;
    ram_re          = 1'b0;
    ram_raddr       = rd_addr_r;
    ph              = phase_r;
    fb              = flag_bits_r;
    fl              = flags_left_r;
    cnt_e           = cnt_r;
    wp_e            = wp_r;
    hlt             = halted_r;
    ok              = 1'b0;
    lit_out         = 1'b0;
    copy_go         = 1'b0;
    nc              = next_code(flag_bits_r, flags_left_r);

    unique case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.first_byte) begin
            ph          = PH_FLAG;
            fb          = '0;
            fl          = '0;
            cnt_e       = '0;
            wp_e        = AW'(1);
            hlt         = 1'b0;
            ref_low_nxt = '0;
          end
          phase_nxt      = ph;
          flag_bits_nxt  = fb;
          flags_left_nxt = fl;
          cnt_nxt        = cnt_e;
          wp_nxt         = wp_e;
          halted_nxt     = hlt;
          nc             = next_code(fb, fl);
          if (!hlt) begin
            unique case (ph)
              PH_FLAG: begin
                flag_bits_nxt  = in_chan.in_byte;
                flags_left_nxt = FLAGS_PER_TAG;
                phase_nxt      = in_chan.in_byte[0] ? PH_REFLO : PH_LIT;
                ok             = 1'b1;
              end
              PH_LIT: begin
                out_load     = 1'b1;
                out_last_nxt = 1'b1;
                if (cnt_e >= max_r) begin
                  out_byte_nxt   = '0;
                  out_status_nxt = ST_LIT_OVF;
                  halted_nxt     = 1'b1;
                end else begin
                  out_byte_nxt   = in_chan.in_byte;
                  out_status_nxt = ST_DATA;
                  out_last_nxt   = !in_chan.last_byte;
                  ram_we         = 1'b1;
                  ram_waddr      = wp_e;
                  ram_wdata      = in_chan.in_byte;
                  wp_nxt         = wp_e + AW'(1);
                  cnt_nxt        = cnt_e + CNT_W'(1);
                  flag_bits_nxt  = nc.bits;
                  flags_left_nxt = nc.left;
                  phase_nxt      = nc.phase;
                  ok             = 1'b1;
                  lit_out        = 1'b1;
                end
              end
              PH_REFLO: begin
                ref_low_nxt = in_chan.in_byte;
                phase_nxt   = PH_REFHI;
                ok          = 1'b1;
              end
              PH_REFHI: begin
                if (offset == '0) begin
                  out_load       = 1'b1;
                  out_byte_nxt   = '0;
                  out_status_nxt = ST_END;
                  out_last_nxt   = 1'b1;
                  halted_nxt     = 1'b1;
                end else if (({1'b0, cnt_e} + (CNT_W+1)'(run_len)) > {1'b0, max_r}) begin
                  out_load       = 1'b1;
                  out_byte_nxt   = '0;
                  out_status_nxt = ST_COPY_OVF;
                  out_last_nxt   = 1'b1;
                  halted_nxt     = 1'b1;
                end else begin
                  ram_re         = 1'b1;
                  ram_raddr      = AW'(offset);
                  rd_addr_nxt    = AW'(offset) + AW'(1);
                  copy_left_nxt  = run_len;
                  cnt_nxt        = cnt_e + CNT_W'(run_len);
                  fwd_nxt        = 1'b0;
                  tail_pend_nxt  = 1'b0;
                  flag_bits_nxt  = nc.bits;
                  flags_left_nxt = nc.left;
                  phase_nxt      = nc.phase;
                  state_nxt      = S_COPY;
                  ok             = 1'b1;
                  copy_go        = 1'b1;
                end
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase

            // stream cut off after this word
            if (ok && in_chan.last_byte) begin
              halted_nxt      = 1'b1;
              tail_status_nxt = trunc_status(phase_nxt);
              if (lit_out) begin
                state_nxt = S_TAIL;
              end else if (copy_go) begin
                tail_pend_nxt = 1'b1;
              end else begin
                out_load       = 1'b1;
                out_byte_nxt   = '0;
                out_status_nxt = trunc_status(phase_nxt);
                out_last_nxt   = 1'b1;
              end
            end
          end
        end
      end

      S_COPY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_nxt   = copy_data;
          out_status_nxt = ST_DATA;
          out_last_nxt   = (copy_left_r == RUN_W'(1)) && !tail_pend_r;
          ram_we         = 1'b1;
          ram_waddr      = wp_r;
          ram_wdata      = copy_data;
          wp_nxt         = wp_r + AW'(1);
          copy_left_nxt  = copy_left_r - RUN_W'(1);
          if (copy_left_r != RUN_W'(1)) begin
            ram_re       = 1'b1;
            rd_addr_nxt  = rd_addr_r + AW'(1);
            fwd_nxt      = (rd_addr_r == wp_r);
            fwd_data_nxt = copy_data;
          end else begin
            state_nxt = tail_pend_r ? S_TAIL : S_IDLE;
          end
        end
      end

      S_TAIL: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_byte_nxt   = '0;
          out_status_nxt = tail_status_r;
          out_last_nxt   = 1'b1;
          tail_pend_nxt  = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      phase_r      <= PH_FLAG;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      ref_low_r    <= '0;
      cnt_r        <= '0;
      max_r        <= MAX_RESET;
      halted_r     <= 1'b0;
      wp_r         <= AW'(1);
      clr_addr_r   <= '0;
      copy_left_r  <= '0;
      fwd_r        <= 1'b0;
      tail_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      ref_low_r    <= ref_low_nxt;
      cnt_r        <= cnt_nxt;
      max_r        <= max_nxt;
      halted_r     <= halted_nxt;
      wp_r         <= wp_nxt;
      clr_addr_r   <= clr_addr_nxt;
      copy_left_r  <= copy_left_nxt;
      fwd_r        <= fwd_nxt;
      tail_pend_r  <= tail_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r     <= rd_addr_nxt;
    fwd_data_r    <= fwd_data_nxt;
    tail_status_r <= tail_status_nxt;
    out_byte_r    <= out_byte_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.last_of_run = out_last_r;

  a_copy_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (copy_left_r != '0))
    else $error("copy running with no bytes left");

  a_tail_only_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    tail_pend_r |-> (state_r == S_COPY || state_r == S_TAIL))
    else $error("truncation pending outside a copy");

  a_fwd_from_copy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fwd_r) |-> $past(state_r == S_COPY))
    else $error("forwarding set outside a copy");

  a_copy_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY && ram_we) |=> out_valid_r)
    else $error("copy byte written to ring but not sent");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for lzss_stream_decompressor_core, with a decoder
// model, a queue-fed word driver, a result monitor and an activity watchdog
// depends on lzsd_pkg, lzsd_in_if, lzsd_out_if and the core itself
module tb import lzsd_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 16384;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
  } comp_word_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic              last;
  } plain_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lzsd_in_if  in_chan ();
  lzsd_out_if out_chan ();

  lzss_stream_decompressor_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // decoder model state
  logic [BYTE_W-1:0] hist [LZSD_WINDOW];
  logic [OFF_W-1:0]  wr_ptr;
  logic [BYTE_W-1:0] flag_reg;
  logic [LEFT_W-1:0] flags_left;
  phase_t            dec_phase;
  logic [BYTE_W-1:0] ref_lo;
  logic [CNT_W-1:0]  produced;
  logic              halted;
  logic [CNT_W-1:0]  max_out_bytes;

  comp_word_t  compressed_words[$];
  plain_word_t decoded_words[$];
  plain_word_t step_results[$];
  comp_word_t  offered;

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int errors = 0;
  int idle_cycles = 0;
  int hold_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_on = 1'b0;

  function automatic void reset_model();
    foreach (hist[i]) hist[i] = '0;
    wr_ptr = OFF_W'(1);
    flag_reg = '0;
    flags_left = '0;
    dec_phase = PH_FLAG;
    ref_lo = '0;
    produced = '0;
    halted = 1'b0;
    max_out_bytes = MAX_RESET;
  endfunction

  function automatic void push_result(input logic [BYTE_W-1:0] d, input status_t st);
    plain_word_t r;
    r.data = d;
    r.status = st;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void store_byte(input logic [BYTE_W-1:0] d);
    hist[wr_ptr] = d;
    wr_ptr++;
    produced++;
    push_result(d, ST_DATA);
  endfunction

  function automatic void advance_code();
    flag_reg = flag_reg >> 1;
    if (flags_left != 0) flags_left--;
    if (flags_left == 0) dec_phase = PH_FLAG;
    else dec_phase = flag_reg[0] ? PH_REFLO : PH_LIT;
  endfunction

  // expected results of one accepted compressed word
  function automatic void decode_step(input comp_word_t w);
    logic [15:0]      ref_word;
    logic [OFF_W-1:0] src;
    int unsigned      copy_len;
    status_t          st;
    step_results.delete();
    if (w.first) begin
      dec_phase = PH_FLAG;
      flags_left = '0;
      flag_reg = '0;
      ref_lo = '0;
      produced = '0;
      wr_ptr = OFF_W'(1);
      halted = 1'b0;
    end
    if (halted) return;
    case (dec_phase)
      PH_FLAG: begin
        flag_reg = w.data;
        flags_left = FLAGS_PER_TAG;
        dec_phase = w.data[0] ? PH_REFLO : PH_LIT;
      end
      PH_LIT: begin
        if (produced >= max_out_bytes) begin
          push_result('0, ST_LIT_OVF);
          halted = 1'b1;
        end else begin
          store_byte(w.data);
          advance_code();
        end
      end
      PH_REFLO: begin
        ref_lo = w.data;
        dec_phase = PH_REFHI;
      end
      default: begin
        ref_word = {w.data, ref_lo};
        src = ref_word[15:4];
        copy_len = 32'(ref_word[3:0]) + 2;
        if (src == 0) begin
          push_result('0, ST_END);
          halted = 1'b1;
        end else if (32'(produced) + copy_len > 32'(max_out_bytes)) begin
          push_result('0, ST_COPY_OVF);
          halted = 1'b1;
        end else begin
          // byte by byte, so an overlapping copy repeats what it just wrote
          for (int k = 0; k < copy_len; k++) begin
            store_byte(hist[src]);
            src++;
          end
          advance_code();
        end
      end
    endcase
    if (!halted && w.last) begin
      if (dec_phase == PH_FLAG) st = ST_NO_TAG;
      else if (dec_phase == PH_LIT) st = ST_NO_LIT;
      else st = ST_NO_REF;
      push_result('0, st);
      halted = 1'b1;
    end
    if (step_results.size() != 0) begin
      step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[i]) decoded_words.push_back(step_results[i]);
    end
  endfunction

  // word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        decode_step(offered);
        accepted_cnt++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (compressed_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = compressed_words.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.in_byte <= offered.data;
          in_chan.first_byte <= offered.first;
          in_chan.last_byte <= offered.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    plain_word_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (decoded_words.size() == 0) begin
          $display("%0t: unexpected word: byte %h status %0d last %b", $time,
                   out_chan.out_byte, out_chan.status, out_chan.last_of_run);
          errors++;
        end else begin
          want = decoded_words.pop_front();
          if (want.data !== out_chan.out_byte || want.status !== out_chan.status ||
              want.last !== out_chan.last_of_run) begin
            $display("%0t: expected byte %h status %0d last %b, got byte %h status %0d last %b",
                     $time, want.data, want.status, want.last,
                     out_chan.out_byte, out_chan.status, out_chan.last_of_run);
            errors++;
          end
        end
      end
      // one long hold-off lets the core back up into its input
      if (hold_on && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lzss_stream_decompressor_core: mismatch");
      $finish;
    end
  end

  task automatic add_word(input logic [BYTE_W-1:0] d, input logic first, input logic last);
    comp_word_t w;
    w.data = d;
    w.first = first;
    w.last = last;
    compressed_words.push_back(w);
    queued_cnt++;
  endtask

  task automatic set_max_output(input logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_out_bytes = v;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (compressed_words.size() != 0 || accepted_cnt != queued_cnt ||
           decoded_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random streams, some closed by an offset-zero reference and some cut off, plus some noise words
  task automatic gen_random(input int n_words);
    comp_word_t       body[$];
    int               made;
    int               groups;
    int               cut;
    logic [BYTE_W-1:0] flags;
    logic [OFF_W-1:0]  src;
    logic [OFF_W-1:0]  gen_wp;
    logic [3:0]        nib;
    made = 0;
    while (made < n_words) begin
      body.delete();
      if ($urandom_range(99) < 10) begin
        add_word(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
        made++;
      end else begin
        gen_wp = OFF_W'(1);
        groups = $urandom_range(3, 1);
        for (int g = 0; g < groups; g++) begin
          flags = 8'($urandom);
          body.push_back('{flags, g == 0, 1'b0});
          for (int k = 0; k < 8; k++) begin
            if (flags[k]) begin
              // mostly reach back into recent output
              if ($urandom_range(3) != 0) src = gen_wp - OFF_W'($urandom_range(24, 1));
              else src = OFF_W'($urandom);
              if (src == 0) src = OFF_W'(1);
              nib = 4'($urandom);
              body.push_back('{{src[3:0], nib}, 1'b0, 1'b0});
              body.push_back('{src[11:4], 1'b0, 1'b0});
              gen_wp += OFF_W'(nib) + OFF_W'(2);
            end else begin
              body.push_back('{8'($urandom), 1'b0, 1'b0});
              gen_wp += OFF_W'(1);
            end
          end
        end
        case ($urandom_range(2))
          0: begin
            // reference with offset zero closes the stream
            body.push_back('{8'($urandom) | 8'h01, 1'b0, 1'b0});
            body.push_back('{{4'h0, 4'($urandom)}, 1'b0, 1'b0});
            body.push_back('{8'h00, 1'b0, 1'($urandom)});
          end
          1: begin
            cut = $urandom_range(body.size() - 1);
            body = body[0:cut];
            body[cut].last = 1'b1;
          end
          default: begin
          end
        endcase
        foreach (body[i]) add_word(body[i].data, body[i].first, body[i].last);
        made += body.size();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.in_byte = '0;
    in_chan.first_byte = 1'b0;
    in_chan.last_byte = 1'b0;
    out_chan.ready = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_max_output(MAX_RESET);

    // literal, overlapping copy, far copy, then cut off after a full flag word
    add_word(8'h06, 1'b1, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'h1F, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'hF0, 1'b0, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'h5A, 1'b0, 1'b0);
    add_word(8'hA5, 1'b0, 1'b0);
    add_word(8'h3C, 1'b0, 1'b0);
    add_word(8'hC3, 1'b0, 1'b1);
    // halted: ignored
    add_word(8'h77, 1'b0, 1'b0);
    // cut off inside a reference
    add_word(8'hFF, 1'b1, 1'b0);
    add_word(8'h12, 1'b0, 1'b1);
    // end of stream on the last word, no cut-off result
    add_word(8'h01, 1'b1, 1'b0);
    add_word(8'h05, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    // restart in mid stream, then cut off waiting for a literal
    add_word(8'h02, 1'b1, 1'b0);
    add_word(8'h11, 1'b0, 1'b0);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'h80, 1'b0, 1'b1);
    wait_idle();

    // overflow on a copy and on a literal
    set_max_output(24'd1);
    add_word(8'h02, 1'b1, 1'b0);
    add_word(8'h01, 1'b0, 1'b0);
    add_word(8'h10, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'h00, 1'b1, 1'b0);
    add_word(8'h02, 1'b0, 1'b0);
    add_word(8'h03, 1'b0, 1'b1);
    wait_idle();

    set_max_output(MAX_RESET);
    gen_random(65);
    wait_idle();

    send_idle_pct <= 53;
    set_max_output(CNT_W'($urandom_range(300, 30)));
    gen_random(65);
    wait_idle();

    send_idle_pct <= 35;
    recv_stall_pct <= 35;
    set_max_output('0);
    gen_random(20);
    wait_idle();

    send_idle_pct <= 0;
    recv_stall_pct <= 53;
    set_max_output(CNT_W'($urandom_range(24'hFFFFFF, 1000)));
    gen_random(65);
    wait_idle();

    send_idle_pct <= 35;
    recv_stall_pct <= 35;
    set_max_output(24'd500);
    gen_random(65);
    wait_idle();

    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    hold_on <= 1'b1;
    set_max_output(MAX_RESET);
    gen_random(50);
    wait_idle();

    if (errors == 0 && decoded_words.size() == 0) begin
      $display("lzss_stream_decompressor_core: match");
    end else begin
      $display("lzss_stream_decompressor_core: mismatch");
    end
    $finish;
  end

endmodule
